>>> rtl/core/sbe_best_bid_ask_decoder_top_macros.svh
// Assertion macros for the best bid/ask decoder.
`ifndef SBE_BEST_BID_ASK_DECODER_TOP_MACROS_SVH
`define SBE_BEST_BID_ASK_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SBE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sbe_bba_pkg.sv
`default_nettype none

package sbe_bba_pkg;

  localparam logic [8:0]  HDR_LEN     = 9'd8;
  localparam logic [8:0]  EVT_END     = 9'd16;
  localparam logic [8:0]  UPD_END     = 9'd24;
  localparam logic [8:0]  EXP_END     = 9'd26;
  localparam logic [8:0]  SYM_LEN_POS = 9'd58;
  localparam logic [8:0]  INDEX_MAX   = 9'd511;
  localparam logic [5:0]  ROOT_BASE   = 6'd26;
  localparam logic [15:0] ROOT_LEN    = 16'd50;
  localparam logic [15:0] TEMPLATE_ID = 16'd10001;
  localparam logic [15:0] SCHEMA_ID   = 16'd1;
  localparam logic [15:0] VERSION_ID  = 16'd0;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT_HDR  = 3'd1,
    ST_SCHEMA     = 3'd2,
    ST_TEMPLATE   = 3'd3,
    ST_BLOCK_LEN  = 3'd4,
    ST_SHORT_ROOT = 3'd5,
    ST_SYMBOL_LEN = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic               end_of_message;
    logic signed [63:0] received_time;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         symbol_char;
    logic signed [63:0] event_time;
    logic signed [63:0] receive_stamp;
    logic signed [63:0] update_id;
    logic signed [7:0]  price_exp;
    logic signed [7:0]  qty_exp;
    logic signed [63:0] bid_px;
    logic signed [63:0] bid_qty;
    logic signed [63:0] ask_px;
    logic signed [63:0] ask_qty;
    status_t            status;
    logic               last;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/core/sbe_best_bid_ask_decoder_top.sv
// Best bid/ask message decoder.
// Input channel (in_valid/in_stall/in_item): one message byte per item, with
// end_of_message on the final byte and the receive timestamp of that byte.
// Output channel (out_valid/out_stall/out_item): one item per symbol byte,
// passed through as it arrives, and one record item (last = 1) per message
// carrying the decoded root fields plus a status code.
// Each result is registered into the output queue as its byte is taken.
// Throughput: one byte per cycle while in_stall is low. A final byte that is
// also a symbol byte yields two items, symbol first, then the record.
// Results sit in a three-entry output queue; in_stall rises while two or
// more are waiting, so one stalled result does not hold up the input.
// While out_stall is high the head item is held unchanged on out_item.
// Reset (rst_n low, synchronous) empties the queue and starts a new message.
`default_nettype none

module sbe_best_bid_ask_decoder_top (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire sbe_bba_pkg::in_item_t in_item,
  output logic                   out_valid,
  input  wire                    out_stall,
  output sbe_bba_pkg::out_item_t out_item
);
  import sbe_bba_pkg::*;

  logic [8:0]        byte_index_r, byte_index_nxt;
  status_t           first_error_r, first_error_nxt;
  logic [7:0]        low_byte_hold_r, low_byte_hold_nxt;
  logic [7:0]        symbol_length_r, symbol_length_nxt;
  logic [63:0]       event_time_r, event_time_nxt;
  logic [63:0]       update_id_r, update_id_nxt;
  logic [1:0][7:0]   exponent_r, exponent_nxt;
  logic [3:0][63:0]  price_qty_r, price_qty_nxt;

  out_item_t [2:0]   queue_r, queue_nxt;
  logic [1:0]        count_r, count_nxt;

  logic              in_fire;
  logic              pop;
  logic [7:0]        b;
  logic [15:0]       hdr_word;
  status_t           hdr_code;
  logic              hdr_bad;
  logic [5:0]        rel;
  logic              sym_hit;
  logic [9:0]        msg_count;
  logic [9:0]        sym_end;
  status_t           status;
  out_item_t         sym_item, rec_item, first_item;
  logic [1:0]        push_cnt;
  out_item_t [2:0]   base_q;
  logic [1:0]        base_cnt;

  assign in_stall  = count_r[1];
  assign out_valid = (count_r != 2'd0);
  assign out_item  = queue_r[0];
  assign in_fire   = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign b         = in_item.data_byte;
  assign hdr_word  = {b, low_byte_hold_r};
  assign rel       = byte_index_r[5:0] - ROOT_BASE;

  always_comb begin
    low_byte_hold_nxt = low_byte_hold_r;
    first_error_nxt   = first_error_r;
    symbol_length_nxt = symbol_length_r;
    event_time_nxt    = event_time_r;
    update_id_nxt     = update_id_r;
    exponent_nxt      = exponent_r;
    price_qty_nxt     = price_qty_r;
    hdr_code          = ST_OK;
    hdr_bad           = 1'b0;
    sym_hit           = 1'b0;

    if (byte_index_r < HDR_LEN) begin
      if (!byte_index_r[0]) begin
        low_byte_hold_nxt = b;
      end else begin
        case (byte_index_r[2:1])
          2'd0: begin
            hdr_bad  = (hdr_word != ROOT_LEN);
            hdr_code = ST_BLOCK_LEN;
          end
          2'd1: begin
            hdr_bad  = (hdr_word != TEMPLATE_ID);
            hdr_code = ST_TEMPLATE;
          end
          2'd2: begin
            hdr_bad  = (hdr_word != SCHEMA_ID);
            hdr_code = ST_SCHEMA;
          end
          default: begin
            hdr_bad  = (hdr_word != VERSION_ID);
            hdr_code = ST_SCHEMA;
          end
        endcase
        if (hdr_bad && (first_error_r == ST_OK || hdr_code < first_error_r)) begin
          first_error_nxt = hdr_code;
        end
      end
    end else if (byte_index_r < EVT_END) begin
      event_time_nxt[{byte_index_r[2:0], 3'b000} +: 8] = b;
    end else if (byte_index_r < UPD_END) begin
      update_id_nxt[{byte_index_r[2:0], 3'b000} +: 8] = b;
    end else if (byte_index_r < EXP_END) begin
      exponent_nxt[byte_index_r[0]] = b;
    end else if (byte_index_r < SYM_LEN_POS) begin
      price_qty_nxt[rel[4:3]][{rel[2:0], 3'b000} +: 8] = b;
    end else if (byte_index_r == SYM_LEN_POS) begin
      symbol_length_nxt = b;
    end else if (byte_index_r <= SYM_LEN_POS + {1'b0, symbol_length_r}) begin
      sym_hit = 1'b1;
    end

    msg_count = {1'b0, byte_index_r} + 10'd1;
    sym_end   = {1'b0, SYM_LEN_POS} + 10'd1 + {2'b00, symbol_length_nxt};
    if (msg_count < {1'b0, HDR_LEN}) begin
      status = ST_SHORT_HDR;
    end else if (first_error_nxt != ST_OK) begin
      status = first_error_nxt;
    end else if (msg_count <= {1'b0, SYM_LEN_POS}) begin
      status = ST_SHORT_ROOT;
    end else if (symbol_length_nxt == 8'd0 || msg_count != sym_end) begin
      status = ST_SYMBOL_LEN;
    end else begin
      status = ST_OK;
    end

    sym_item             = '0;
    sym_item.symbol_char = b;
    sym_item.status      = ST_OK;

    rec_item               = '0;
    rec_item.receive_stamp = in_item.received_time;
    rec_item.status        = status;
    rec_item.last          = 1'b1;
    if (status == ST_OK) begin
      rec_item.event_time = event_time_r;
      rec_item.update_id  = update_id_r;
      rec_item.price_exp  = exponent_r[0];
      rec_item.qty_exp    = exponent_r[1];
      rec_item.bid_px     = price_qty_r[0];
      rec_item.bid_qty    = price_qty_r[1];
      rec_item.ask_px     = price_qty_r[2];
      rec_item.ask_qty    = price_qty_r[3];
    end

    if (in_item.end_of_message) begin
      byte_index_nxt    = '0;
      first_error_nxt   = ST_OK;
      low_byte_hold_nxt = '0;
      symbol_length_nxt = '0;
    end else if (byte_index_r != INDEX_MAX) begin
      byte_index_nxt = byte_index_r + 9'd1;
    end else begin
      byte_index_nxt = byte_index_r;
    end
  end

  always_comb begin
    first_item = sym_hit ? sym_item : rec_item;
    push_cnt   = '0;
    if (in_fire) begin
      push_cnt = {1'b0, sym_hit} + {1'b0, in_item.end_of_message};
    end

    if (pop) begin
      base_q   = {queue_r[2], queue_r[2], queue_r[1]};
      base_cnt = count_r - 2'd1;
    end else begin
      base_q   = queue_r;
      base_cnt = count_r;
    end

    queue_nxt = base_q;
    for (int i = 0; i < 3; i++) begin
      if (push_cnt != 2'd0 && base_cnt == 2'(i)) begin
        queue_nxt[i] = first_item;
      end
      if (push_cnt == 2'd2 && base_cnt + 2'd1 == 2'(i)) begin
        queue_nxt[i] = rec_item;
      end
    end
    count_nxt = base_cnt + push_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r    <= '0;
      first_error_r   <= ST_OK;
      low_byte_hold_r <= '0;
      symbol_length_r <= '0;
      count_r         <= '0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        byte_index_r    <= byte_index_nxt;
        first_error_r   <= first_error_nxt;
        low_byte_hold_r <= low_byte_hold_nxt;
        symbol_length_r <= symbol_length_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    queue_r <= queue_nxt;
    if (in_fire) begin
      event_time_r <= event_time_nxt;
      update_id_r  <= update_id_nxt;
      exponent_r   <= exponent_nxt;
      price_qty_r  <= price_qty_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sbe_bba_checker.sv
`default_nettype none

`include "sbe_best_bid_ask_decoder_top_macros.svh"

module sbe_bba_checker (
  input wire                    clk,
  input wire                    rst_n,
  input wire                    in_stall,
  input wire                    out_valid,
  input wire                    out_stall,
  input wire sbe_bba_pkg::out_item_t out_item
);
  import sbe_bba_pkg::*;

  logic error_rec;
  logic data_zero;
  logic held;
  logic rec_valid;
  logic sym_valid;
  logic sym_clean;

  assign held      = out_valid && out_stall;
  assign rec_valid = out_valid && out_item.last;
  assign sym_valid = out_valid && !out_item.last;
  assign error_rec = rec_valid && (out_item.status != ST_OK);
  assign data_zero = (out_item.event_time == 64'sd0) && (out_item.update_id == 64'sd0)
                  && (out_item.price_exp == 8'sd0) && (out_item.qty_exp == 8'sd0)
                  && (out_item.bid_px == 64'sd0) && (out_item.bid_qty == 64'sd0)
                  && (out_item.ask_px == 64'sd0) && (out_item.ask_qty == 64'sd0);
  assign sym_clean = (out_item.status == ST_OK) && (out_item.receive_stamp == 64'sd0)
                  && data_zero;

  `SBE_ASSERT_NEXT(a_out_hold, clk, rst_n, held, out_valid && $stable(out_item), "held item changed")
  `SBE_ASSERT_IMPL(a_err_zero, clk, rst_n, error_rec, data_zero, "error record carries data")
  `SBE_ASSERT_IMPL(a_sym_clean, clk, rst_n, sym_valid, sym_clean, "symbol item has record fields")
  `SBE_ASSERT_IMPL(a_rec_char, clk, rst_n, rec_valid, out_item.symbol_char == 8'd0, "record has a char")
  `SBE_ASSERT_IMPL(a_stall_busy, clk, rst_n, in_stall, out_valid, "input stalled with no item out")

endmodule

bind sbe_best_bid_ask_decoder_top sbe_bba_checker u_sbe_bba_checker (.*);

`default_nettype wire

>>> tb/sbe_best_bid_ask_decoder_top_tb.sv
`timescale 1ns / 100ps

module sbe_best_bid_ask_decoder_top_tb;
  import sbe_bba_pkg::*;

  localparam logic [63:0] I64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_BYTES = 250;
  localparam int PLAN_ROWS = 20;

  typedef enum logic [2:0] {
    ROOT_ZERO,
    ROOT_ONES,
    ROOT_MIN,
    ROOT_MAX,
    ROOT_RAND
  } root_mode_t;

  typedef struct {
    int                 len;
    logic [15:0]        blk;
    logic [15:0]        tmpl;
    logic [15:0]        schema;
    logic [15:0]        version;
    logic [7:0]         sym_len;
    root_mode_t         mode;
    logic signed [63:0] stamp;
    bit                 typed;
    status_t            exp_status;
    logic [63:0]        exp_w;
    logic [7:0]         exp_b;
  } msg_desc_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  wire       in_stall;
  in_item_t  in_item = '0;
  wire       out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  sbe_best_bid_ask_decoder_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // decoder state mirror
  logic [8:0]  msg_pos;
  status_t     hdr_err;
  logic [7:0]  half_word;
  logic [7:0]  sym_len;
  logic [63:0] evt_acc;
  logic [63:0] upd_acc;
  logic [7:0]  exp_acc [2];
  logic [63:0] book_acc [4];

  out_item_t awaited_items[$];
  out_item_t head_item;
  msg_desc_t plan [PLAN_ROWS];

  int  fail_count = 0;
  int  bytes_sent = 0;
  int  msgs_sent = 0;
  int  records_seen = 0;
  int  symbols_seen = 0;
  logic [6:0] statuses_seen = '0;
  bit  tx_quiet = 1'b0;
  bit  rx_quiet = 1'b0;
  bit  hold_req = 1'b0;

  function automatic void clear_decoder();
    msg_pos = '0;
    hdr_err = ST_OK;
    half_word = '0;
    sym_len = '0;
    evt_acc = '0;
    upd_acc = '0;
    exp_acc[0] = '0;
    exp_acc[1] = '0;
    for (int i = 0; i < 4; i++) book_acc[i] = '0;
  endfunction

  function automatic void note_hdr_error(status_t code);
    if (hdr_err == ST_OK || code < hdr_err) hdr_err = code;
  endfunction

  function automatic void decode_byte(input in_item_t it, input msg_desc_t d);
    out_item_t   rec;
    logic [15:0] word;
    logic [8:0]  rel;
    logic [7:0]  b;
    int          cnt;
    status_t     st;
    b = it.data_byte;
    if (msg_pos < HDR_LEN) begin
      if (!msg_pos[0]) begin
        half_word = b;
      end else begin
        word = {b, half_word};
        if (msg_pos == 9'd1 && word != ROOT_LEN) note_hdr_error(ST_BLOCK_LEN);
        if (msg_pos == 9'd3 && word != TEMPLATE_ID) note_hdr_error(ST_TEMPLATE);
        if (msg_pos == 9'd5 && word != SCHEMA_ID) note_hdr_error(ST_SCHEMA);
        if (msg_pos == 9'd7 && word != VERSION_ID) note_hdr_error(ST_SCHEMA);
      end
    end else if (msg_pos < EVT_END) begin
      evt_acc[msg_pos[2:0]*8 +: 8] = b;
    end else if (msg_pos < UPD_END) begin
      upd_acc[msg_pos[2:0]*8 +: 8] = b;
    end else if (msg_pos < EXP_END) begin
      exp_acc[msg_pos[0]] = b;
    end else if (msg_pos < SYM_LEN_POS) begin
      rel = msg_pos - 9'd26;
      book_acc[rel[4:3]][rel[2:0]*8 +: 8] = b;
    end else if (msg_pos == SYM_LEN_POS) begin
      sym_len = b;
    end else if (int'(msg_pos) <= int'(SYM_LEN_POS) + int'(sym_len)) begin
      rec = '0;
      rec.symbol_char = b;
      awaited_items = {awaited_items, rec};
    end

    if (!it.end_of_message) begin
      if (msg_pos < INDEX_MAX) msg_pos = msg_pos + 9'd1;
      return;
    end

    cnt = int'(msg_pos) + 1;
    if (cnt < int'(HDR_LEN)) st = ST_SHORT_HDR;
    else if (hdr_err != ST_OK) st = hdr_err;
    else if (cnt <= int'(SYM_LEN_POS)) st = ST_SHORT_ROOT;
    else if (sym_len == 0 || cnt != int'(SYM_LEN_POS) + 1 + int'(sym_len)) st = ST_SYMBOL_LEN;
    else st = ST_OK;

    rec = '0;
    rec.receive_stamp = it.received_time;
    rec.last = 1'b1;
    if (d.typed) begin
      rec.receive_stamp = d.stamp;
      rec.status = d.exp_status;
      rec.event_time = d.exp_w;
      rec.update_id = d.exp_w;
      rec.price_exp = d.exp_b;
      rec.qty_exp = d.exp_b;
      rec.bid_px = d.exp_w;
      rec.bid_qty = d.exp_w;
      rec.ask_px = d.exp_w;
      rec.ask_qty = d.exp_w;
    end else begin
      rec.status = st;
      if (st == ST_OK) begin
        rec.event_time = evt_acc;
        rec.update_id = upd_acc;
        rec.price_exp = exp_acc[0];
        rec.qty_exp = exp_acc[1];
        rec.bid_px = book_acc[0];
        rec.bid_qty = book_acc[1];
        rec.ask_px = book_acc[2];
        rec.ask_qty = book_acc[3];
      end
    end
    awaited_items = {awaited_items, rec};
    clear_decoder();
  endfunction

  function automatic logic [7:0] msg_byte(input msg_desc_t d, input int p);
    logic [63:0] hdr;
    bit          top;
    logic [7:0]  b;
    hdr = {d.version, d.schema, d.tmpl, d.blk};
    top = (p == 15) || (p == 23) || (p == 24) || (p == 25) ||
          (p == 33) || (p == 41) || (p == 49) || (p == 57);
    if (p < 8) begin
      b = hdr[p*8 +: 8];
    end else if (p < 58) begin
      case (d.mode)
        ROOT_ZERO: b = 8'h00;
        ROOT_ONES: b = 8'hFF;
        ROOT_MIN:  b = top ? 8'h80 : 8'h00;
        ROOT_MAX:  b = top ? 8'h7F : 8'hFF;
        default:   b = 8'($urandom_range(0, 255));
      endcase
    end else if (p == 58) begin
      b = d.sym_len;
    end else begin
      b = 8'($urandom_range(0, 255));
    end
    return b;
  endfunction

  task automatic send_message(input msg_desc_t d);
    in_item_t it;
    int       gap;
    for (int p = 0; p < d.len; p++) begin
      it.data_byte = msg_byte(d, p);
      it.end_of_message = (p == d.len - 1);
      it.received_time = it.end_of_message ? d.stamp : {$urandom, $urandom};
      gap = tx_quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_item <= it;
      do @(posedge clk); while (in_stall);
      decode_byte(it, d);
      bytes_sent++;
    end
    msgs_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_items.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string fname, input logic [63:0] e, input logic [63:0] a);
    if (a !== e) begin
      if (fail_count < 10)
        $display("mismatch in %s (record %0d): expected %h, got %h",
                 fname, records_seen, e, a);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_items.size() == 0) begin
        if (fail_count < 10) $display("output item with nothing expected: %h", out_item);
        fail_count++;
      end else begin
        head_item = awaited_items.pop_front();
        check_field("symbol_char", head_item.symbol_char, out_item.symbol_char);
        check_field("event_time", head_item.event_time, out_item.event_time);
        check_field("receive_stamp", head_item.receive_stamp, out_item.receive_stamp);
        check_field("update_id", head_item.update_id, out_item.update_id);
        check_field("price_exp", head_item.price_exp, out_item.price_exp);
        check_field("qty_exp", head_item.qty_exp, out_item.qty_exp);
        check_field("bid_px", head_item.bid_px, out_item.bid_px);
        check_field("bid_qty", head_item.bid_qty, out_item.bid_qty);
        check_field("ask_px", head_item.ask_px, out_item.ask_px);
        check_field("ask_qty", head_item.ask_qty, out_item.ask_qty);
        check_field("status", head_item.status, out_item.status);
        check_field("last", head_item.last, out_item.last);
      end
      if (out_item.last) begin
        records_seen++;
        statuses_seen[out_item.status] = 1'b1;
      end else begin
        symbols_seen++;
      end
    end
  end

  // receiver: random stalls per item, one long hold on request
  initial begin
    int n;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        n = rx_quiet ? 0 : $urandom_range(0, 8);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      if ($urandom_range(0, 31) == 0) rx_quiet = !rx_quiet;
    end
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d items still awaited", awaited_items.size());
    $display("[sbe_best_bid_ask_decoder_top] ERROR");
    $finish;
  end

  initial begin
    msg_desc_t d;
    int        k;
    int        c;
    int        rand_start;
    bit        pressure_done;
    clear_decoder();
    pressure_done = 1'b0;

    plan[0]  = '{1, ROOT_LEN, TEMPLATE_ID, SCHEMA_ID, VERSION_ID, 8'd0, ROOT_ZERO,
                 I64_MIN, 1, ST_SHORT_HDR, 64'd0, 8'd0};
    plan[1]  = '{7, ROOT_LEN, TEMPLATE_ID, SCHEMA_ID, VERSION_ID, 8'd0, ROOT_ZERO,
                 I64_MAX, 1, ST_SHORT_HDR, 64'd0, 8'd0};
    plan[2]  = '{4, 16'd51, TEMPLATE_ID, SCHEMA_ID, VERSION_ID, 8'd0, ROOT_ZERO,
                 64'd0, 1, ST_SHORT_HDR, 64'd0, 8'd0};
    plan[3]  = '{8, 16'd49, TEMPLATE_ID, SCHEMA_ID, VERSION_ID, 8'd0, ROOT_ZERO,
                 ALL_ONES, 1, ST_BLOCK_LEN, 64'd0, 8'd0};
    plan[4]  = '{8, ROOT_LEN, 16'd10002, SCHEMA_ID, VERSION_ID, 8'd0, ROOT_ZERO,
                 64'd12345, 1, ST_TEMPLATE, 64'd0, 8'd0};
    plan[5]  = '{8, ROOT_LEN, TEMPLATE_ID, 16'd2, VERSION_ID, 8'd0, ROOT_ZERO,
                 64'd1, 1, ST_SCHEMA, 64'd0, 8'd0};
    plan[6]  = '{8, ROOT_LEN, TEMPLATE_ID, SCHEMA_ID, 16'd1, 8'd0, ROOT_ZERO,
                 64'd2, 1, ST_SCHEMA, 64'd0, 8'd0};
    plan[7]  = '{8, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 8'd0, ROOT_ZERO,
                 64'd3, 1, ST_SCHEMA, 64'd0, 8'd0};
    plan[8]  = '{8, ROOT_LEN, TEMPLATE_ID, SCHEMA_ID, VERSION_ID, 8'd0, ROOT_ZERO,
                 64'd4, 1, ST_SHORT_ROOT, 64'd0, 8'd0};
    plan[9]  = '{58, ROOT_LEN, TEMPLATE_ID, SCHEMA_ID, VERSION_ID, 8'd0, ROOT_ONES,
                 64'd5, 1, ST_SHORT_ROOT, 64'd0, 8'd0};
    plan[10] = '{59, ROOT_LEN, TEMPLATE_ID, SCHEMA_ID, VERSION_ID, 8'd0, ROOT_ONES,
                 64'd6, 1, ST_SYMBOL_LEN, 64'd0, 8'd0};
    plan[11] = '{64, ROOT_LEN, TEMPLATE_ID, SCHEMA_ID, VERSION_ID, 8'd5, ROOT_ONES,
                 I64_MIN, 1, ST_OK, ALL_ONES, 8'hFF};
    plan[12] = '{64, ROOT_LEN, TEMPLATE_ID, SCHEMA_ID, VERSION_ID, 8'd5, ROOT_MIN,
                 I64_MAX, 1, ST_OK, I64_MIN, 8'h80};
    plan[13] = '{64, ROOT_LEN, TEMPLATE_ID, SCHEMA_ID, VERSION_ID, 8'd5, ROOT_MAX,
                 ALL_ONES, 1, ST_OK, I64_MAX, 8'h7F};
    plan[14] = '{62, ROOT_LEN, TEMPLATE_ID, SCHEMA_ID, VERSION_ID, 8'd5, ROOT_RAND,
                 64'd7, 1, ST_SYMBOL_LEN, 64'd0, 8'd0};
    plan[15] = '{70, ROOT_LEN, TEMPLATE_ID, SCHEMA_ID, VERSION_ID, 8'd3, ROOT_RAND,
                 64'd8, 1, ST_SYMBOL_LEN, 64'd0, 8'd0};
    plan[16] = '{314, ROOT_LEN, TEMPLATE_ID, SCHEMA_ID, VERSION_ID, 8'd255, ROOT_RAND,
                 64'd9, 0, ST_OK, 64'd0, 8'd0};
    plan[17] = '{64, ROOT_LEN, 16'd0, SCHEMA_ID, VERSION_ID, 8'd5, ROOT_RAND,
                 64'd10, 1, ST_TEMPLATE, 64'd0, 8'd0};
    plan[18] = '{520, ROOT_LEN, TEMPLATE_ID, SCHEMA_ID, VERSION_ID, 8'd255, ROOT_RAND,
                 64'd11, 1, ST_SYMBOL_LEN, 64'd0, 8'd0};
    plan[19] = '{60, ROOT_LEN, TEMPLATE_ID, SCHEMA_ID, VERSION_ID, 8'd1, ROOT_ZERO,
                 I64_MIN, 1, ST_OK, 64'd0, 8'd0};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      send_message(plan[i]);
    end
    wait_for_results();

    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RANDOM_BYTES) begin
      d.blk = ROOT_LEN;
      d.tmpl = TEMPLATE_ID;
      d.schema = SCHEMA_ID;
      d.version = VERSION_ID;
      d.sym_len = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(1, 255))
                                               : 8'($urandom_range(1, 8));
      d.len = 59 + d.sym_len;
      k = $urandom_range(0, 9);
      d.mode = (k < 4) ? root_mode_t'(k) : ROOT_RAND;
      d.stamp = {$urandom, $urandom};
      d.typed = 1'b0;
      d.exp_status = ST_OK;
      d.exp_w = '0;
      d.exp_b = '0;
      tx_quiet = ($urandom_range(0, 3) == 0);

      k = $urandom_range(0, 9);
      if (!pressure_done && msgs_sent >= PLAN_ROWS) begin
        // hold the output while a long message streams in
        d.sym_len = 8'd40;
        d.len = 99;
        tx_quiet = 1'b1;
        hold_req = 1'b1;
        pressure_done = 1'b1;
      end else if (k >= 8) begin
        d.blk = 16'($urandom);
        d.tmpl = 16'($urandom);
        d.schema = 16'($urandom);
        d.version = 16'($urandom);
        d.sym_len = 8'($urandom_range(0, 255));
        d.len = $urandom_range(1, 70);
      end else if (k >= 6) begin
        c = $urandom_range(0, 5);
        case (c)
          0: d.blk = 16'($urandom);
          1: d.tmpl = 16'($urandom);
          2: d.schema = 16'($urandom_range(0, 3));
          3: d.version = 16'($urandom_range(0, 3));
          4: d.len = $urandom_range(1, d.len + 4);
          default: begin
            d.sym_len = 8'd0;
            if ($urandom_range(0, 1) == 0) d.len = 59;
          end
        endcase
      end
      send_message(d);
      if (d.len == 99 && tx_quiet && !hold_req && pressure_done && msgs_sent == PLAN_ROWS + 1)
        wait_for_results();
    end

    wait_for_results();
    repeat (20) @(posedge clk);

    $display("ran %0d messages (%0d bytes); checked %0d records and %0d symbol items",
             msgs_sent, bytes_sent, records_seen, symbols_seen);
    $display("status codes observed (bit per code): %b, mismatches: %0d",
             statuses_seen, fail_count);
    if (fail_count == 0 && awaited_items.size() == 0) begin
      $display("[sbe_best_bid_ask_decoder_top] OK");
    end else begin
      $display("[sbe_best_bid_ask_decoder_top] ERROR");
    end
    $finish;
  end

endmodule
